// ===== rtl/lslc_pkg.sv =====
`default_nettype none
package lslc_pkg;

  localparam int CNT_W       = 16;
  localparam int LUX_W       = 21;
  localparam int BASE_W      = 15;
  localparam int SCALE_W     = 19;
  localparam int CH_SHIFT    = 10;
  localparam int CH_W        = CNT_W + SCALE_W - CH_SHIFT;
  localparam int RATIO_SHIFT = 9;
  localparam int NUM_W       = CH_W + RATIO_SHIFT + 1;
  localparam int LIM_W       = 11;
  localparam int TH_W        = CH_W + LIM_W;
  localparam int NUM_LIM     = 7;
  localparam int SEG_W       = 3;
  localparam int COEF_W      = 10;
  localparam int PROD_W      = CH_W + COEF_W;
  localparam int LUX_SHIFT   = 14;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_GAIN  = 1'b0;
  localparam logic REG_INTEG = 1'b1;

  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;

  localparam logic [BASE_W-1:0] SCALE_T0    = 15'h7517;
  localparam logic [BASE_W-1:0] SCALE_T1    = 15'h0fe7;
  localparam logic [BASE_W-1:0] SCALE_UNITY = 15'h0400;

  localparam logic [SEG_W-1:0] SEG_FIRST = 3'd0;
  localparam logic [SEG_W-1:0] SEG_LAST  = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0]  c0;
    logic [CH_W-1:0]  c1;
    logic [SEG_W-1:0] seg;
  } item_t;

  // 2*limit+1: rounded ratio <= limit exactly when (c1 << 10) < (2*limit+1)*c0
  function automatic logic [LIM_W-1:0] th_coef(input logic [SEG_W-1:0] k);
    logic [LIM_W-1:0] r;
    case (k)
      3'd0:    r = 11'd129;
      3'd1:    r = 11'd257;
      3'd2:    r = 11'd385;
      3'd3:    r = 11'd513;
      3'd4:    r = 11'd625;
      3'd5:    r = 11'd821;
      3'd6:    r = 11'd1333;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] seg_b(input logic [SEG_W-1:0] s);
    logic [COEF_W-1:0] r;
    case (s)
      3'd0:    r = 10'h1f2;
      3'd1:    r = 10'h214;
      3'd2:    r = 10'h23f;
      3'd3:    r = 10'h270;
      3'd4:    r = 10'h16f;
      3'd5:    r = 10'h0d2;
      3'd6:    r = 10'h018;
      default: r = 10'h000;
    endcase
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] seg_m(input logic [SEG_W-1:0] s);
    logic [COEF_W-1:0] r;
    case (s)
      3'd0:    r = 10'h1be;
      3'd1:    r = 10'h2d1;
      3'd2:    r = 10'h37b;
      3'd3:    r = 10'h3fe;
      3'd4:    r = 10'h1fc;
      3'd5:    r = 10'h0fb;
      3'd6:    r = 10'h012;
      default: r = 10'h000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lslc_front.sv =====
`default_nettype none
module lslc_front
  import lslc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [CNT_W-1:0]  broadband_count_i,
  input  wire logic [CNT_W-1:0]  infrared_count_i,
  input  wire logic              gain_high_i,
  input  wire logic [1:0]        integration_code_i,
  output logic                   push_o,
  output item_t                  item_o
);

  logic [BASE_W-1:0]          base;
  logic [SCALE_W-1:0]         scale;
  logic [CNT_W+SCALE_W-1:0]   p0, p1;

  logic                       s1_v_q;
  logic [CH_W-1:0]            s1_c0_q, s1_c1_q;

  logic                       s2_v_q;
  logic [CH_W-1:0]            s2_c0_q, s2_c1_q;
  logic [NUM_W-1:0]           s2_num_q;
  logic [TH_W-1:0]            s2_th_q [NUM_LIM];

  logic [NUM_LIM-1:0]         below;
  logic [SEG_W-1:0]           seg;

  always_comb begin
    case (integration_code_i)
      INTEG_13MS:  base = SCALE_T0;
      INTEG_101MS: base = SCALE_T1;
      default:     base = SCALE_UNITY;
    endcase
    scale = gain_high_i ? SCALE_W'(base) : {base, 4'b0000};
    p0 = (CNT_W+SCALE_W)'(broadband_count_i) * (CNT_W+SCALE_W)'(scale);
    p1 = (CNT_W+SCALE_W)'(infrared_count_i) * (CNT_W+SCALE_W)'(scale);
  end

  // scale stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_c0_q <= p0[CNT_W+SCALE_W-1:CH_SHIFT];
      s1_c1_q <= p1[CNT_W+SCALE_W-1:CH_SHIFT];
    end
  end

  // breakpoint products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_c0_q  <= s1_c0_q;
      s2_c1_q  <= s1_c1_q;
      s2_num_q <= {s1_c1_q, {(RATIO_SHIFT+1){1'b0}}};
      for (int k = 0; k < NUM_LIM; k++) begin
        s2_th_q[k] <= TH_W'(s1_c0_q) * TH_W'(th_coef(SEG_W'(k)));
      end
    end
  end

  // pick the first segment whose breakpoint is not exceeded; zero c0 forces the first segment
  always_comb begin
    for (int k = 0; k < NUM_LIM; k++) begin
      below[k] = TH_W'(s2_num_q) < s2_th_q[k];
    end
    seg = SEG_LAST;
    for (int k = NUM_LIM - 1; k >= 0; k--) begin
      if (below[k]) seg = SEG_W'(k);
    end
    if (s2_c0_q == '0) seg = SEG_FIRST;
  end

  assign push_o      = s2_v_q;
  assign item_o.c0   = s2_c0_q;
  assign item_o.c1   = s2_c1_q;
  assign item_o.seg  = seg;

endmodule
`default_nettype wire

// ===== rtl/lslc_queue.sv =====
`default_nettype none
module lslc_queue
  import lslc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   accept_i,
  output logic        full_o,
  input  wire logic   push_i,
  input  wire item_t  item_i,
  output logic        avail_o,
  output item_t       item_o,
  input  wire logic   pop_i
);

  item_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;
  logic [Q_CNT_W-1:0]   credit_q, credit_d;

  // credits cover words still in the front plus words held here
  always_comb begin
    credit_d = credit_q;
    if (accept_i && !pop_i) credit_d = credit_q + Q_CNT_W'(1);
    if (!accept_i && pop_i) credit_d = credit_q - Q_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      credit_q <= credit_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + Q_CNT_W'(1);
      if (!push_i && pop_i) cnt_q <= cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign full_o  = (credit_q == Q_CNT_W'(Q_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== rtl/lslc_back.sv =====
`default_nettype none
module lslc_back
  import lslc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              avail_i,
  input  wire item_t             item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [LUX_W-1:0]       lux_o
);

  logic                 b1_v_q;
  logic [PROD_W-1:0]    pos_q, neg_q;
  logic                 b2_v_q;
  logic [LUX_W-1:0]     lux_q;

  logic                 b2_load, b1_load;
  logic [PROD_W:0]      rounded;

  assign b2_load = b1_v_q && (!b2_v_q || !out_stall_i);
  assign b1_load = avail_i && (!b1_v_q || b2_load);
  assign pop_o   = b1_load;

  // clamp at zero, then round to whole lux
  assign rounded = (pos_q > neg_q)
                 ? (PROD_W+1)'(pos_q - neg_q) + (PROD_W+1)'(1 << (LUX_SHIFT - 1))
                 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      if (b1_load)      b1_v_q <= 1'b1;
      else if (b2_load) b1_v_q <= 1'b0;
      if (b2_load)           b2_v_q <= 1'b1;
      else if (!out_stall_i) b2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_load) begin
      pos_q <= PROD_W'(item_i.c0) * PROD_W'(seg_b(item_i.seg));
      neg_q <= PROD_W'(item_i.c1) * PROD_W'(seg_m(item_i.seg));
    end
    if (b2_load) lux_q <= rounded[LUX_SHIFT+LUX_W-1:LUX_SHIFT];
  end

  assign out_valid_o = b2_v_q;
  assign lux_o       = lux_q;

endmodule
`default_nettype wire

// ===== rtl/light_sensor_lux_calc_top.sv =====
// Datapath: scale stage, breakpoint stage, queue, product register and output register.
// Throughput: one word per cycle while neither side stalls; the front takes a word each
// cycle while it holds credit for an 8-entry queue, and the back drains one word per cycle
// into the output register while out_stall_i is low.
// Reset: rst_ni clears all valid flags, pointers and credits asynchronously and loads
// gain_high = 1 and integration_code = 2; payload registers are not reset.
`default_nettype none
module light_sensor_lux_calc_top
  import lslc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  // input word
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CNT_W-1:0]   broadband_count_i,
  input  wire logic [CNT_W-1:0]   infrared_count_i,
  // result word
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [LUX_W-1:0]        lux_o
);

  logic        gain_high_q;
  logic [1:0]  integration_code_q;
  logic        cfg_wr;
  logic        in_accept;

  logic        push;
  item_t       push_item;
  logic        avail;
  item_t       head_item;
  logic        pop;

  // Register file: word index lives in paddr[2]; pready is always high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_high_q        <= 1'b1;
      integration_code_q <= 2'd2;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_GAIN:  gain_high_q        <= pwdata[0];
        REG_INTEG: integration_code_q <= pwdata[1:0];
        default:   gain_high_q        <= gain_high_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GAIN:  prdata = DATA_W'(gain_high_q);
      REG_INTEG: prdata = DATA_W'(integration_code_q);
      default:   prdata = '0;
    endcase
  end

  // Accept a word only while the queue still has a credit for it.
  assign in_accept = in_valid_i && !in_stall_o;

  // Front: scale both channels and pick the linear segment.
  lslc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .broadband_count_i  (broadband_count_i),
    .infrared_count_i   (infrared_count_i),
    .gain_high_i        (gain_high_q),
    .integration_code_i (integration_code_q),
    .push_o             (push),
    .item_o             (push_item)
  );

  // Queue: decouple the front from output back-pressure.
  lslc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .full_o   (in_stall_o),
    .push_i   (push),
    .item_i   (push_item),
    .avail_o  (avail),
    .item_o   (head_item),
    .pop_i    (pop)
  );

  // Back: weight the channels, clamp, round and hold the result word.
  lslc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lux_o       (lux_o)
  );

endmodule
`default_nettype wire

// ===== test/tb_light_sensor_lux_calc_top.sv =====
`default_nettype none
module tb_light_sensor_lux_calc_top;
  import lslc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register map: one 32-bit register per index, byte address = 4 * index.
  localparam logic [ADDR_W-1:0] ADDR_GAIN  = {REG_GAIN, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_INTEG = {REG_INTEG, 2'b00};

  localparam logic       GAIN_LOW       = 1'b0;
  localparam logic       GAIN_HIGH      = 1'b1;
  localparam logic [1:0] INTEG_402MS    = 2'd2;

  // Fixed-point layout of the lux computation.
  localparam int          FRAC_BITS   = 10;  // integration factor in 2^10 units
  localparam int          RATIO_BITS  = 9;   // ratio in 2^9 units
  localparam int          LUX_BITS    = 14;  // final shift of the lux sum
  localparam int unsigned FACTOR_13MS = 32'h7517;
  localparam int unsigned FACTOR_101MS = 32'h0fe7;
  localparam int unsigned FACTOR_UNIT = 32'h0400;

  localparam int RANDOM_PER_SETTING = 250;
  localparam int SETTLE_CYCLES      = 12;   // margin beyond the block's latency

  typedef struct packed {
    logic [CNT_W-1:0] broadband;
    logic [CNT_W-1:0] infrared;
  } reading_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // Register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Input and result channels
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] bb_drv    = '0;
  logic [CNT_W-1:0] ir_drv    = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [LUX_W-1:0] lux;

  light_sensor_lux_calc_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .broadband_count_i (bb_drv),
    .infrared_count_i  (ir_drv),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .lux_o             (lux)
  );

  // Readings waiting to go out, and lux words owed by the block in order.
  reading_t         readings [$];
  logic [LUX_W-1:0] lux_due  [$];

  // Shadow copy of the configuration, updated on every completed write.
  logic       gain_shadow  = GAIN_HIGH;
  logic [1:0] integ_shadow = INTEG_402MS;

  logic        calm          = 1'b0;  // suppress idling and stalls near the end
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  int unsigned err_count     = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned settings_run  = 0;

  // Upper ratio bound of segment k (rounded ratio in 2^9 units).
  function automatic int unsigned breakpoint(input int k);
    int unsigned r;
    case (k)
      0:       r = 32'h040;
      1:       r = 32'h080;
      2:       r = 32'h0c0;
      3:       r = 32'h100;
      4:       r = 32'h138;
      5:       r = 32'h19a;
      default: r = 32'h29a;
    endcase
    return r;
  endfunction

  // Expected lux for one reading pair under the given gain and integration time.
  function automatic logic [LUX_W-1:0] lux_of(input reading_t r, input logic gain,
                                              input logic [1:0] integ);
    longint unsigned factor, c0, c1, ratio, pos, neg, sum;
    longint unsigned b, m;
    int              seg;
    int              k;
    case (integ)
      INTEG_13MS:  factor = FACTOR_13MS;
      INTEG_101MS: factor = FACTOR_101MS;
      default:     factor = FACTOR_UNIT;
    endcase
    if (gain == GAIN_LOW) factor = factor << 4;
    c0 = (longint'(r.broadband) * factor) >> FRAC_BITS;
    c1 = (longint'(r.infrared) * factor) >> FRAC_BITS;
    // zero broadband forces the first segment
    ratio = 0;
    if (c0 != 0) ratio = (c1 << (RATIO_BITS + 1)) / c0;
    ratio = (ratio + 1) >> 1;
    // a ratio sitting on a breakpoint stays in the lower segment
    seg = 7;
    for (k = 6; k >= 0; k--)
      if (ratio <= breakpoint(k)) seg = k;
    case (seg)
      0:       begin b = 64'h1f2; m = 64'h1be; end
      1:       begin b = 64'h214; m = 64'h2d1; end
      2:       begin b = 64'h23f; m = 64'h37b; end
      3:       begin b = 64'h270; m = 64'h3fe; end
      4:       begin b = 64'h16f; m = 64'h1fc; end
      5:       begin b = 64'h0d2; m = 64'h0fb; end
      6:       begin b = 64'h018; m = 64'h012; end
      default: begin b = 64'h000; m = 64'h000; end
    endcase
    pos = c0 * b;
    neg = c1 * m;
    sum = (neg >= pos) ? 64'd0 : pos - neg;
    sum = (sum + (64'd1 << (LUX_BITS - 1))) >> LUX_BITS;
    return sum[LUX_W-1:0];
  endfunction

  // Draw one random reading, biased toward realistic infrared fractions.
  function automatic reading_t random_reading();
    reading_t    r;
    int unsigned pick, frac, tmp;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      // infrared as a fraction of broadband, reaching every segment
      r.broadband = CNT_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
      frac        = $urandom_range(0, 1400);
      tmp         = (int'(r.broadband) * frac) / 1024;
      r.infrared  = (tmp > 65535) ? 16'hffff : tmp[CNT_W-1:0];
    end else if (pick <= 7) begin
      r.broadband = CNT_W'($urandom_range(0, 65535));
      r.infrared  = CNT_W'($urandom_range(0, 65535));
    end else if (pick == 8) begin
      r.broadband = CNT_W'($urandom_range(0, 7));
      r.infrared  = CNT_W'($urandom_range(0, 7));
    end else begin
      r.broadband = ($urandom_range(0, 1) != 0) ? CNT_W'(16'hffff - $urandom_range(0, 1))
                                                : CNT_W'($urandom_range(0, 1));
      r.infrared  = ($urandom_range(0, 1) != 0) ? CNT_W'(16'hffff - $urandom_range(0, 1))
                                                : CNT_W'($urandom_range(0, 1));
    end
    return r;
  endfunction

  function automatic reading_t pair(input int unsigned bb, input int unsigned ir);
    reading_t r;
    r.broadband = bb[CNT_W-1:0];
    r.infrared  = ir[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Extremes, clamp to zero, and both sides of every segment breakpoint.
  task automatic queue_directed();
    int k;
    readings.push_back(pair(0, 0));
    readings.push_back(pair(0, 1));
    readings.push_back(pair(0, 65535));      // zero broadband: clamps to zero
    readings.push_back(pair(1, 0));
    readings.push_back(pair(1, 1));
    readings.push_back(pair(65535, 0));
    readings.push_back(pair(65535, 1));
    readings.push_back(pair(65535, 65535));
    readings.push_back(pair(1024, 2047));    // ratio far above the last segment
    // with broadband 1024 at unity scale the rounded ratio is (ir+1)/2
    for (k = 0; k < 7; k++) begin
      readings.push_back(pair(1024, 2 * breakpoint(k)));
      readings.push_back(pair(1024, 2 * breakpoint(k) + 1));
    end
  endtask

  // Hold until every queued reading has gone in and its lux word has come back.
  // Sample on the falling edge so the driver's updates of that cycle have settled.
  task automatic wait_drained();
    while (readings.size() != 0 || in_valid || lux_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // the block masks the value to the register width
    case (addr)
      ADDR_GAIN:  gain_shadow  = data[0];
      ADDR_INTEG: integ_shadow = data[1:0];
      default:    ;
    endcase
  endtask

  task automatic reg_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [DATA_W-1:0] rd;
    reg_read(ADDR_GAIN, rd);
    if (rd !== DATA_W'(gain_shadow))
      note_error($sformatf("gain_high read %0h, expected %0h", rd, gain_shadow));
    reg_read(ADDR_INTEG, rd);
    if (rd !== DATA_W'(integ_shadow))
      note_error($sformatf("integration_code read %0h, expected %0h", rd, integ_shadow));
  endtask

  // Driver: present the next reading once the current word is taken; insert idle bursts.
  always @(posedge clk_i) begin : drive_readings
    reading_t nxt;
    logic     load;
    nxt  = pair(bb_drv, ir_drv);
    load = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        // word accepted: record its lux under the configuration in force now
        lux_due.push_back(lux_of(nxt, gain_shadow, integ_shadow));
        words_sent++;
      end
      // hold the payload while stalled, otherwise advance
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (readings.size() != 0) begin
          nxt  = readings.pop_front();
          load = 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
        end
        in_valid <= load;
        if (load) begin
          bb_drv <= nxt.broadband;
          ir_drv <= nxt.infrared;
        end
      end
    end
  end

  // Monitor: check each lux word taken against the oldest one owed; stall in bursts.
  always @(posedge clk_i) begin : check_lux
    logic [LUX_W-1:0] want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (lux_due.size() == 0) begin
          note_error($sformatf("lux word %0d with none outstanding", lux));
        end else begin
          want = lux_due.pop_front();
          words_checked++;
          if (lux !== want)
            note_error($sformatf("lux mismatch on word %0d: expected %0d, got %0d",
                                 words_checked, want, lux));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: reset, directed pass at reset settings, then a sweep of every setting.
  initial begin : run_sequence
    int g, ic, n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first, then directed readings under them
    check_regs();
    queue_directed();
    wait_drained();
    settings_run++;

    // sweep all gain and integration settings; the final one runs without idling
    for (g = 0; g < 2; g++) begin
      for (ic = 0; ic < 4; ic++) begin
        if (g == 1 && ic == 3) calm <= 1'b1;
        // junk in the upper bits must be dropped by the register
        reg_write(ADDR_GAIN, {16'($urandom_range(0, 65535)), 15'h0, g[0]});
        reg_write(ADDR_INTEG, {16'($urandom_range(0, 65535)), 14'h0, ic[1:0]});
        check_regs();
        queue_directed();
        for (n = 0; n < RANDOM_PER_SETTING; n++) readings.push_back(random_reading());
        wait_drained();
        settings_run++;
      end
    end

    if (lux_due.size() != 0)
      note_error($sformatf("%0d lux words never arrived", lux_due.size()));
    $display("Sent %0d reading pairs over %0d gain/integration settings, checked %0d lux words.",
             words_sent, settings_run, words_checked);
    $display("Mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lslc_pkg.sv
rtl/lslc_front.sv
rtl/lslc_queue.sv
rtl/lslc_back.sv
rtl/light_sensor_lux_calc_top.sv
test/tb_light_sensor_lux_calc_top.sv
